### src/zsd_pkg.sv
// ----------------------------------------------------------------------------
// zsd_pkg
// Shared types, constants and codes of the ZNCC stereo disparity block.
// ----------------------------------------------------------------------------
package zsd_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int WIN        = 9;
   localparam int MAX_DISP   = 64;
   localparam int N_PIX      = WIN * WIN;

   localparam int PIX_W      = 8;
   localparam int POS_W      = 9;
   localparam int DIM_W      = 10;
   localparam int DISP_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int N_CELLS    = 5;

   localparam int WIN_W  = $clog2(WIN);
   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int XW     = $clog2(MAX_WIDTH + 2 * MAX_DISP + WIN + 1024) + 1;
   localparam int YW     = $clog2(MAX_HEIGHT + WIN + 1024);
   localparam int ACC_W  = $clog2(N_PIX * 255 * 255 + 1);
   localparam int MW     = $clog2(longint'(N_PIX) * N_PIX * 255 * 255 + 1);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_MAX_DISPARITY,
      CSR_CROSS_CHECK_LIMIT
   } csr_index_type;

   typedef enum logic [2:0] {
      SEL_A,
      SEL_B,
      SEL_AA,
      SEL_BB,
      SEL_AB
   } cell_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_DRAIN,
      ST_SCORE,
      ST_RESP
   } top_state_type;

   typedef enum logic [3:0] {
      SC_IDLE,
      SC_SASB,
      SC_SASA,
      SC_SBSB,
      SC_CHECK,
      SC_N2,
      SC_PP,
      SC_LHS,
      SC_RHS,
      SC_CMP,
      SC_TAKE
   } score_state_type;

   typedef struct packed {
      logic              op;
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  row;
      logic [PIX_W-1:0]  image0_pixel;
      logic [PIX_W-1:0]  image1_pixel;
   } req_type;

   typedef struct packed {
      logic [DISP_W-1:0] disparity;
      logic              consistent;
   } rsp_type;

   typedef struct packed {
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] b;
   } pix_pair_type;

   typedef struct packed {
      logic                 start;
      logic signed [XW-1:0] xa;
      logic signed [XW-1:0] xb;
      logic [YW-1:0]        y;
   } fetch_cmd_type;

   typedef struct packed {
      logic              clear;
      logic              start;
      logic [DISP_W-1:0] d;
   } score_cmd_type;

endpackage

### src/zsd_cell.sv
// ----------------------------------------------------------------------------
// zsd_cell
// One accumulation cell of the window chain: adds its own term of the pixel
// pair and hands the pair on to the next cell.
// ----------------------------------------------------------------------------
module zsd_cell import zsd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cell_sel_type       sel,
   input  logic               clr,
   input  logic               in_valid,
   input  pix_pair_type       in_pair,
   output logic               out_valid,
   output pix_pair_type       out_pair,
   output logic [ACC_W-1:0]   acc
);

   logic               out_valid_ff;
   pix_pair_type       out_pair_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   acc_in;
   logic [PIX_W-1:0]   op_x;
   logic [PIX_W-1:0]   op_y;
   logic [2*PIX_W-1:0] term;

   always_comb begin
      case (sel)
         SEL_A: begin
            op_x = in_pair.a;
            op_y = PIX_W'(1);
         end
         SEL_B: begin
            op_x = in_pair.b;
            op_y = PIX_W'(1);
         end
         SEL_AA: begin
            op_x = in_pair.a;
            op_y = in_pair.a;
         end
         SEL_BB: begin
            op_x = in_pair.b;
            op_y = in_pair.b;
         end
         SEL_AB: begin
            op_x = in_pair.a;
            op_y = in_pair.b;
         end
         default: begin
            op_x = in_pair.a;
            op_y = PIX_W'(1);
         end
      endcase
      term = (2*PIX_W)'(op_x) * (2*PIX_W)'(op_y);
      acc_in = acc_ff;
      if (clr) begin
         acc_in = '0;
      end else if (in_valid) begin
         acc_in = acc_ff + ACC_W'(term);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_pair_ff <= in_pair;
      acc_ff      <= acc_in;
   end

   assign out_valid = out_valid_ff;
   assign out_pair  = out_pair_ff;
   assign acc       = acc_ff;

endmodule

### src/zsd_fetch.sv
// ----------------------------------------------------------------------------
// zsd_fetch
// Image stores and window walker: one pixel pair read per cycle, pixels
// outside the image in use read as zero.
// ----------------------------------------------------------------------------
module zsd_fetch import zsd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  fetch_cmd_type      cmd,
   input  logic [DIM_W-1:0]   eff_w,
   input  logic [DIM_W-1:0]   eff_h,
   input  logic               wr_en,
   input  logic [POS_W-1:0]   wr_col,
   input  logic [POS_W-1:0]   wr_row,
   input  pix_pair_type       wr_pair,
   output logic               busy,
   output logic               pix_valid,
   output pix_pair_type       pix
);

   logic [PIX_W-1:0] mem0 [MAX_WIDTH*MAX_HEIGHT];
   logic [PIX_W-1:0] mem1 [MAX_WIDTH*MAX_HEIGHT];

   logic                 busy_ff;
   logic                 pix_valid_ff;
   logic [WIN_W-1:0]     i_ff;
   logic [WIN_W-1:0]     j_ff;
   logic signed [XW-1:0] xa_ff;
   logic signed [XW-1:0] xb_ff;
   logic [YW-1:0]        y_ff;
   logic                 ina_ff;
   logic                 inb_ff;
   logic [PIX_W-1:0]     rd0_ff;
   logic [PIX_W-1:0]     rd1_ff;

   logic signed [XW-1:0] xa_cur;
   logic signed [XW-1:0] xb_cur;
   logic [YW-1:0]        y_cur;
   logic                 y_ok;
   logic                 ina;
   logic                 inb;
   logic [ADDR_W-1:0]    addr_a;
   logic [ADDR_W-1:0]    addr_b;
   logic [ADDR_W-1:0]    waddr;
   logic                 wr_ok;

   always_comb begin
      xa_cur = xa_ff + $signed(XW'(i_ff));
      xb_cur = xb_ff + $signed(XW'(i_ff));
      y_cur  = y_ff + YW'(j_ff);
      y_ok   = y_cur < YW'(eff_h);
      ina    = (xa_cur >= 0) && (xa_cur < $signed(XW'(eff_w))) && y_ok;
      inb    = (xb_cur >= 0) && (xb_cur < $signed(XW'(eff_w))) && y_ok;
      addr_a = ADDR_W'(y_cur) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xa_cur);
      addr_b = ADDR_W'(y_cur) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xb_cur);
      waddr  = ADDR_W'(wr_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(wr_col);
      wr_ok  = (int'(wr_col) < MAX_WIDTH) && (int'(wr_row) < MAX_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem0[waddr] <= wr_pair.a;
         mem1[waddr] <= wr_pair.b;
      end
      rd0_ff <= mem0[addr_a];
      rd1_ff <= mem1[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pix_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         pix_valid_ff <= busy_ff;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            i_ff    <= '0;
            j_ff    <= '0;
         end else if (busy_ff) begin
            if (i_ff == WIN_W'(WIN - 1)) begin
               i_ff <= '0;
               if (j_ff == WIN_W'(WIN - 1)) begin
                  busy_ff <= 1'b0;
               end else begin
                  j_ff <= j_ff + WIN_W'(1);
               end
            end else begin
               i_ff <= i_ff + WIN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         xa_ff <= cmd.xa;
         xb_ff <= cmd.xb;
         y_ff  <= cmd.y;
      end
      ina_ff <= ina;
      inb_ff <= inb;
   end

   assign busy      = busy_ff;
   assign pix_valid = pix_valid_ff;
   assign pix.a     = ina_ff ? rd0_ff : '0;
   assign pix.b     = inb_ff ? rd1_ff : '0;

endmodule

### src/zsd_score.sv
// ----------------------------------------------------------------------------
// zsd_score
// Correlation scoring: forms numerator and variances from the window sums,
// compares against the best so far by exact cross-multiplication on one
// shared multiplier, and keeps the winning disparity.
// ----------------------------------------------------------------------------
module zsd_score import zsd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  score_cmd_type      cmd,
   input  logic [ACC_W-1:0]   sa,
   input  logic [ACC_W-1:0]   sb,
   input  logic [ACC_W-1:0]   saa,
   input  logic [ACC_W-1:0]   sbb,
   input  logic [ACC_W-1:0]   sab,
   output logic               busy,
   output logic [DISP_W-1:0]  best
);

   score_state_type      state_ff;
   score_state_type      state_in;
   logic                 have_ff;
   logic [DISP_W-1:0]    best_ff;
   logic [DISP_W-1:0]    d_ff;
   logic [2*MW-1:0]      t_ff;
   logic signed [MW:0]   num_ff;
   logic [MW-1:0]        pa_ff;
   logic [MW-1:0]        pb_ff;
   logic [2*MW-1:0]      n2_ff;
   logic [2*MW-1:0]      pp_ff;
   logic [2*MW-1:0]      bn2_ff;
   logic [2*MW-1:0]      bpp_ff;
   logic [2*MW-1:0]      prod_ff;
   logic [4*MW-1:0]      lhs_ff;
   logic [4*MW-1:0]      rhs_ff;
   logic [2:0]           part_ff;
   logic [1:0]           sh_ff;

   logic [MW-1:0]        nsab;
   logic [MW-1:0]        nsaa;
   logic [MW-1:0]        nsbb;
   logic signed [MW:0]   num_calc;
   logic [MW-1:0]        pa_calc;
   logic [MW-1:0]        pb_calc;
   logic [2*MW-1:0]      src1;
   logic [2*MW-1:0]      src2;
   logic [MW-1:0]        mul_x;
   logic [MW-1:0]        mul_y;
   logic [2*MW-1:0]      prod;
   logic [4*MW-1:0]      addend;

   always_comb begin
      nsab     = MW'(N_PIX) * MW'(sab);
      nsaa     = MW'(N_PIX) * MW'(saa);
      nsbb     = MW'(N_PIX) * MW'(sbb);
      num_calc = $signed({1'b0, nsab}) - $signed({1'b0, t_ff[MW-1:0]});
      pa_calc  = nsaa - t_ff[MW-1:0];
      pb_calc  = nsbb - t_ff[MW-1:0];

      src1 = (state_ff == SC_RHS) ? bn2_ff : n2_ff;
      src2 = (state_ff == SC_RHS) ? pp_ff : bpp_ff;

      case (state_ff)
         SC_SASB: begin
            mul_x = MW'(sa);
            mul_y = MW'(sb);
         end
         SC_SASA: begin
            mul_x = MW'(sa);
            mul_y = MW'(sa);
         end
         SC_SBSB: begin
            mul_x = MW'(sb);
            mul_y = MW'(sb);
         end
         SC_N2: begin
            mul_x = num_ff[MW-1:0];
            mul_y = num_ff[MW-1:0];
         end
         SC_PP: begin
            mul_x = pa_ff;
            mul_y = pb_ff;
         end
         SC_LHS, SC_RHS: begin
            mul_x = part_ff[0] ? src1[2*MW-1:MW] : src1[MW-1:0];
            mul_y = part_ff[1] ? src2[2*MW-1:MW] : src2[MW-1:0];
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
      prod = (2*MW)'(mul_x) * (2*MW)'(mul_y);

      case (sh_ff)
         2'd0:    addend = (4*MW)'(prod_ff);
         2'd1:    addend = (4*MW)'(prod_ff) << MW;
         default: addend = (4*MW)'(prod_ff) << (2*MW);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SC_IDLE: begin
            if (cmd.start) begin
               state_in = SC_SASB;
            end
         end
         SC_SASB:  state_in = SC_SASA;
         SC_SASA:  state_in = SC_SBSB;
         SC_SBSB:  state_in = SC_CHECK;
         SC_CHECK: begin
            if (num_ff <= 0 || pa_ff == '0 || pb_calc == '0) begin
               state_in = SC_IDLE;
            end else begin
               state_in = SC_N2;
            end
         end
         SC_N2:    state_in = SC_PP;
         SC_PP:    state_in = have_ff ? SC_LHS : SC_TAKE;
         SC_LHS: begin
            if (part_ff == 3'd4) begin
               state_in = SC_RHS;
            end
         end
         SC_RHS: begin
            if (part_ff == 3'd4) begin
               state_in = SC_CMP;
            end
         end
         SC_CMP:   state_in = (lhs_ff > rhs_ff) ? SC_TAKE : SC_IDLE;
         SC_TAKE:  state_in = SC_IDLE;
         default:  state_in = SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         have_ff  <= 1'b0;
         best_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (cmd.clear) begin
            have_ff <= 1'b0;
            best_ff <= '0;
         end else if (state_ff == SC_TAKE) begin
            have_ff <= 1'b1;
            best_ff <= d_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         SC_IDLE: begin
            if (cmd.start) begin
               d_ff <= cmd.d;
            end
         end
         SC_SASB: begin
            t_ff <= prod;
         end
         SC_SASA: begin
            num_ff <= num_calc;
            t_ff   <= prod;
         end
         SC_SBSB: begin
            pa_ff <= pa_calc;
            t_ff  <= prod;
         end
         SC_CHECK: begin
            pb_ff <= pb_calc;
         end
         SC_N2: begin
            n2_ff <= prod;
         end
         SC_PP: begin
            pp_ff   <= prod;
            lhs_ff  <= '0;
            rhs_ff  <= '0;
            part_ff <= '0;
         end
         SC_LHS, SC_RHS: begin
            prod_ff <= prod;
            sh_ff   <= 2'(part_ff[0]) + 2'(part_ff[1]);
            if (part_ff != 3'd0) begin
               if (state_ff == SC_LHS) begin
                  lhs_ff <= lhs_ff + addend;
               end else begin
                  rhs_ff <= rhs_ff + addend;
               end
            end
            part_ff <= (part_ff == 3'd4) ? 3'd0 : part_ff + 3'd1;
         end
         SC_TAKE: begin
            bn2_ff <= n2_ff;
            bpp_ff <= pp_ff;
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != SC_IDLE);
   assign best = best_ff;

endmodule

### src/zncc_stereo_disparity_cross_check.sv
// ----------------------------------------------------------------------------
// zncc_stereo_disparity_cross_check
// ZNCC block matching over two stored gray images with a left-right
// consistency check on the two views' disparities.
//
//   channel  ports                                      moves
//   req      req_valid / req_ready / req_data           pixel load or query
//   rsp      rsp_valid / rsp_ready / rsp_data           one result per query
//   csr      csr_write_enable / csr_index / csr_write_data   register write
//
// A load is written into the stores as it is accepted. A query walks the window
// one pixel pair per cycle through the memory read port and the cell chain for
// each disparity, two searches of max_disparity+1 (capped at 64) each.
// A border query skips both searches. Reset is synchronous; the image stores
// are not cleared. A result waiting in the output register stalls only the
// next query's final transfer.
// ----------------------------------------------------------------------------
module zncc_stereo_disparity_cross_check import zsd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   top_state_type        state_ff;
   top_state_type        state_in;
   logic [DIM_W-1:0]     width_ff;
   logic [DIM_W-1:0]     height_ff;
   logic [DISP_W-1:0]    maxd_ff;
   logic [DISP_W-1:0]    limit_ff;
   logic [POS_W-1:0]     col_ff;
   logic [POS_W-1:0]     row_ff;
   logic                 mode_ff;
   logic [DISP_W-1:0]    d_ff;
   logic signed [XW-1:0] x_ff;
   logic [DISP_W-1:0]    dr_ff;
   rsp_type              result_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic [DIM_W-1:0]     eff_w;
   logic [DIM_W-1:0]     eff_h;
   logic [DISP_W-1:0]    eff_maxd;
   logic                 req_xfer;
   logic                 border;
   logic                 drained;
   logic                 rsp_load;
   logic                 search_done;
   logic [DISP_W-1:0]    diff;

   fetch_cmd_type        fetch_cmd;
   score_cmd_type        score_cmd;
   logic                 fetch_busy;
   logic                 pix_valid;
   pix_pair_type         pix;
   logic                 score_busy;
   logic [DISP_W-1:0]    best;

   logic                 chain_valid [N_CELLS+1];
   pix_pair_type         chain_pair  [N_CELLS+1];
   logic [ACC_W-1:0]     accs        [N_CELLS];

   always_comb begin
      eff_w    = (int'(width_ff) < MAX_WIDTH) ? width_ff : DIM_W'(MAX_WIDTH);
      eff_h    = (int'(height_ff) < MAX_HEIGHT) ? height_ff : DIM_W'(MAX_HEIGHT);
      eff_maxd = (int'(maxd_ff) < MAX_DISP) ? maxd_ff : DISP_W'(MAX_DISP);
      req_xfer = req_valid && req_ready;
      border   = ((DIM_W+1)'(req_data.col) + (DIM_W+1)'(2) >= (DIM_W+1)'(eff_w)) ||
                 ((DIM_W+1)'(req_data.row) + (DIM_W+1)'(2) >= (DIM_W+1)'(eff_h));
      drained  = !fetch_busy && !pix_valid && !chain_valid[1] && !chain_valid[2] &&
                 !chain_valid[3] && !chain_valid[4] && !chain_valid[5];
      search_done = (d_ff == eff_maxd);
      diff     = (best >= dr_ff) ? best - dr_ff : dr_ff - best;
      rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      fetch_cmd.start = 1'b0;
      fetch_cmd.xa    = mode_ff ? x_ff + $signed(XW'(d_ff)) : x_ff;
      fetch_cmd.xb    = mode_ff ? x_ff : x_ff - $signed(XW'(d_ff));
      fetch_cmd.y     = YW'(row_ff);
      score_cmd.clear = 1'b0;
      score_cmd.start = 1'b0;
      score_cmd.d     = d_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_xfer && req_data.op == OP_QUERY) begin
               score_cmd.clear = 1'b1;
               state_in = border ? ST_RESP : ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            fetch_cmd.start = 1'b1;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drained) begin
               score_cmd.start = 1'b1;
               state_in = ST_SCORE;
            end
         end
         ST_SCORE: begin
            if (!score_busy) begin
               if (search_done) begin
                  if (!mode_ff) begin
                     score_cmd.clear = 1'b1;
                     state_in = ST_LAUNCH;
                  end else begin
                     state_in = ST_RESP;
                  end
               end else begin
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= DIM_W'(512);
         height_ff    <= DIM_W'(512);
         maxd_ff      <= DISP_W'(64);
         limit_ff     <= DISP_W'(5);
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:       width_ff  <= csr_write_data;
               CSR_IMAGE_HEIGHT:      height_ff <= csr_write_data;
               CSR_MAX_DISPARITY:     maxd_ff   <= csr_write_data[DISP_W-1:0];
               CSR_CROSS_CHECK_LIMIT: limit_ff  <= csr_write_data[DISP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            col_ff    <= req_data.col;
            row_ff    <= req_data.row;
            mode_ff   <= 1'b0;
            d_ff      <= '0;
            x_ff      <= $signed(XW'(req_data.col));
            result_ff <= '0;
         end
         ST_SCORE: begin
            if (!score_busy) begin
               if (search_done) begin
                  if (!mode_ff) begin
                     dr_ff   <= best;
                     mode_ff <= 1'b1;
                     d_ff    <= '0;
                     x_ff    <= $signed(XW'(col_ff)) - $signed(XW'(best));
                  end else if (diff <= limit_ff) begin
                     result_ff.disparity  <= dr_ff;
                     result_ff.consistent <= 1'b1;
                  end
               end else begin
                  d_ff <= d_ff + DISP_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   zsd_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .cmd       (fetch_cmd),
      .eff_w     (eff_w),
      .eff_h     (eff_h),
      .wr_en     (req_xfer && req_data.op == OP_LOAD),
      .wr_col    (req_data.col),
      .wr_row    (req_data.row),
      .wr_pair   ({req_data.image0_pixel, req_data.image1_pixel}),
      .busy      (fetch_busy),
      .pix_valid (pix_valid),
      .pix       (pix)
   );

   assign chain_valid[0] = pix_valid;
   assign chain_pair[0]  = pix;

   for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
      zsd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .sel       (cell_sel_type'(3'(k))),
         .clr       (fetch_cmd.start),
         .in_valid  (chain_valid[k]),
         .in_pair   (chain_pair[k]),
         .out_valid (chain_valid[k+1]),
         .out_pair  (chain_pair[k+1]),
         .acc       (accs[k])
      );
   end

   zsd_score u_score (
      .clock (clock),
      .reset (reset),
      .cmd   (score_cmd),
      .sa    (accs[SEL_A]),
      .sb    (accs[SEL_B]),
      .saa   (accs[SEL_AA]),
      .sbb   (accs[SEL_BB]),
      .sab   (accs[SEL_AB]),
      .busy  (score_busy),
      .best  (best)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
